>>> rtl/fpls_pkg.sv
// ----------------------------------------------------------------------------
// fpls_pkg: shared definitions for the five-point Laplacian stencil unit
// Field widths, register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package fpls_pkg;

  // Sample and result formats (signed Q16.16), gain format (unsigned Q16.16).
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LAP_W    = 32;
  localparam int unsigned GAIN_W   = 32;
  localparam int unsigned FRAC_W   = 16;

  // Grid size registers and their legal floor.
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned MIN_DIM = 3;

  // Default grid capacity.
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // Configuration port geometry.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_H_SQ    = 2'd2;

  // Reset values.
  localparam logic [DIM_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]  GRID_HEIGHT_RST = 11'd1024;
  localparam logic [GAIN_W-1:0] INV_H_SQ_RST    = 32'h0001_0000;

  // Configuration as seen by the datapath; restart pulses on a size write.
  typedef struct packed {
    logic [DIM_W-1:0]  grid_width;
    logic [DIM_W-1:0]  grid_height;
    logic [GAIN_W-1:0] inv_h_sq;
    logic              restart;
  } cfg_t;

endpackage

>>> rtl/fpls_cfg_regs.sv
// ----------------------------------------------------------------------------
// fpls_cfg_regs: APB register file
// Holds grid width, grid height and gain, and flags a frame restart whenever
// a size register is written.
// ----------------------------------------------------------------------------
module fpls_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fpls_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fpls_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fpls_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output fpls_pkg::cfg_t                     cfg_o
);
  import fpls_pkg::*;

  logic [DIM_W-1:0]     grid_width_q, grid_height_q;
  logic [GAIN_W-1:0]    inv_h_sq_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;

  // Register writes in the access phase; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
      inv_h_sq_q    <= INV_H_SQ_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[DIM_W-1:0];
        REG_INV_H_SQ:    inv_h_sq_q    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width_q);
      REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height_q);
      REG_INV_H_SQ:    prdata = APB_DATA_W'(inv_h_sq_q);
      default:         prdata = '0;
    endcase
  end

  // A size write restarts the frame at the same edge.
  assign cfg_o.grid_width  = grid_width_q;
  assign cfg_o.grid_height = grid_height_q;
  assign cfg_o.inv_h_sq    = inv_h_sq_q;
  assign cfg_o.restart     = wr_en &&
                             ((reg_idx == REG_GRID_WIDTH) || (reg_idx == REG_GRID_HEIGHT));

endmodule

>>> rtl/fpls_line_buf.sv
// ----------------------------------------------------------------------------
// fpls_line_buf: line buffer memory
// One entry per column holding the sample of the row above and of the row
// two above, with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fpls_line_buf #(
  parameter  int unsigned DEPTH  = fpls_pkg::MAX_WIDTH_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [ADDR_W-1:0]               rd_addr_i,
  output logic [2*fpls_pkg::SAMPLE_W-1:0] rd_data_o,
  input  logic                            wr_en_i,
  input  logic [ADDR_W-1:0]               wr_addr_i,
  input  logic [2*fpls_pkg::SAMPLE_W-1:0] wr_data_i
);
  import fpls_pkg::*;

  logic [2*SAMPLE_W-1:0] mem [DEPTH];
  logic [2*SAMPLE_W-1:0] rd_data_q;

  // Write and registered read; the read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/fpls_scale.sv
// ----------------------------------------------------------------------------
// fpls_scale: gain, rounding and saturation pipeline
// Takes the raw stencil sum, multiplies its magnitude by the Q16.16 gain,
// rounds to nearest with ties away from zero and clips to 32 bits.
// ----------------------------------------------------------------------------
module fpls_scale #(
  parameter int unsigned TAG_W = 21
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [fpls_pkg::SAMPLE_W+3:0] in_sum_i,
  input  logic [TAG_W-1:0]                     in_tag_i,
  input  logic [fpls_pkg::GAIN_W-1:0]          gain_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fpls_pkg::LAP_W-1:0]           out_lap_o,
  output logic                                 out_sat_o,
  output logic [TAG_W-1:0]                     out_tag_o
);
  import fpls_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + 4;
  localparam int unsigned LO_W  = 32;
  localparam int unsigned HI_W  = SUM_W - LO_W;
  localparam int unsigned LP_W  = LO_W + GAIN_W;
  localparam int unsigned HP_W  = HI_W + GAIN_W;
  localparam int unsigned RND_W = LP_W + 1 - FRAC_W;
  localparam int unsigned Q_W   = RND_W + 1;

  // Stage A: registered sum.
  logic                    va_q;
  logic signed [SUM_W-1:0] suma_q;
  logic [TAG_W-1:0]        taga_q;
  // Stage B: sign and magnitude.
  logic                    vb_q, negb_q;
  logic [SUM_W-1:0]        magb_q;
  logic [TAG_W-1:0]        tagb_q;
  // Stage C: partial products.
  logic                    vc_q, negc_q;
  logic [LP_W-1:0]         loc_q;
  logic [HP_W-1:0]         hic_q;
  logic [TAG_W-1:0]        tagc_q;
  // Stage D: clipped magnitude.
  logic                    vd_q, negd_q, satd_q;
  logic [LAP_W-1:0]        qd_q;
  logic [TAG_W-1:0]        tagd_q;
  // Output register.
  logic                    vo_q, sato_q;
  logic [LAP_W-1:0]        lapo_q;
  logic [TAG_W-1:0]        tago_q;

  logic                    rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
  logic [SUM_W-1:0]        mag_d;
  logic [LP_W-1:0]         lo_d;
  logic [HP_W-1:0]         hi_d;
  logic [LP_W:0]           rnd_sum;
  logic [Q_W-1:0]          q_full, q_lim;
  logic                    sat_d;
  logic [LAP_W-1:0]        q_d;

  // Each stage loads when it is empty or its contents move on.
  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy_d      = !vd_q || rdy_o;
  assign rdy_c      = !vc_q || rdy_d;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // Magnitude of the sum.
  assign mag_d = suma_q[SUM_W-1] ? (SUM_W'(0) - $unsigned(suma_q)) : $unsigned(suma_q);

  // Low and high partial products of magnitude times gain.
  assign lo_d = LP_W'(magb_q[LO_W-1:0]) * LP_W'(gain_i);
  assign hi_d = HP_W'(magb_q[SUM_W-1:LO_W]) * HP_W'(gain_i);

  // Round to Q16.16 and clip the magnitude at the signed limit.
  always_comb begin
    rnd_sum = {1'b0, loc_q} + (LP_W+1)'(1 << (FRAC_W - 1));
    q_full  = Q_W'({hic_q[FRAC_W-1:0], {FRAC_W{1'b0}}}) + Q_W'(rnd_sum[LP_W:FRAC_W]);
    q_lim   = negc_q ? Q_W'(33'h0_8000_0000) : Q_W'(33'h0_7FFF_FFFF);
    sat_d   = (|hic_q[HP_W-1:FRAC_W]) || (q_full > q_lim);
    q_d     = sat_d ? q_lim[LAP_W-1:0] : q_full[LAP_W-1:0];
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
      if (rdy_o) vo_q <= vd_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      suma_q <= in_sum_i;
      taga_q <= in_tag_i;
    end
    if (rdy_b) begin
      negb_q <= suma_q[SUM_W-1];
      magb_q <= mag_d;
      tagb_q <= taga_q;
    end
    if (rdy_c) begin
      negc_q <= negb_q;
      loc_q  <= lo_d;
      hic_q  <= hi_d;
      tagc_q <= tagb_q;
    end
    if (rdy_d) begin
      negd_q <= negc_q;
      satd_q <= sat_d;
      qd_q   <= q_d;
      tagd_q <= tagc_q;
    end
    if (rdy_o) begin
      lapo_q <= negd_q ? (LAP_W'(0) - qd_q) : qd_q;
      sato_q <= satd_q;
      tago_q <= tagd_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_lap_o   = lapo_q;
  assign out_sat_o   = sato_q;
  assign out_tag_o   = tago_q;

  // A clipped result always sits exactly on one of the two limits.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && sato_q) |-> ((lapo_q == 32'h7FFF_FFFF) || (lapo_q == 32'h8000_0000)))
    else $error("saturated result is not at a limit");

endmodule

>>> rtl/five_point_laplacian_stencil_unit.sv
// ----------------------------------------------------------------------------
// five_point_laplacian_stencil_unit: streaming five-point Laplacian
// Grid samples (signed Q16.16) enter on the slave stream in raster order,
// column fastest, one sample per beat. Each interior cell yields one result
// beat: gain * (up + down + left + right - 4 * centre), rounded and clipped to
// signed Q16.16, with its column and row; border cells give no beat.
// The result for centre (r-1, c-1) appears once sample (r, c) has arrived.
// Throughput is one sample per cycle while the receiver does not stall: the
// line buffer memory is read once and written once per sample, and the gain
// multiply is a single pipelined stage.
// tlast marks the last interior cell of a frame; tuser flags clipping.
// The APB port sets width, height (a write restarts the frame at row and
// column zero) and the gain; write it only while no beats are in flight.
// Reset empties the pipeline and zeroes the counters; line buffer contents
// are not cleared, since rows 0 and 1 of each frame refill them before use.
// When the receiver stalls, results queue in the pipeline registers and the
// slave side keeps taking samples until every stage is full.
// ----------------------------------------------------------------------------
module five_point_laplacian_stencil_unit #(
  parameter  int unsigned MAX_WIDTH  = fpls_pkg::MAX_WIDTH_DEF,
  parameter  int unsigned MAX_HEIGHT = fpls_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned CW         = $clog2(MAX_WIDTH),
  localparam int unsigned RW         = $clog2(MAX_HEIGHT),
  localparam int unsigned OUT_W      = ((fpls_pkg::LAP_W + CW + RW + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Slave stream, tdata: sample [31:0].
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [fpls_pkg::SAMPLE_W-1:0]   s_axis_tdata,
  // Master stream, tdata: lap_value, center_col, center_row, zero padding.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_W-1:0]                m_axis_tdata,
  // tuser: saturated.
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpls_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fpls_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fpls_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import fpls_pkg::*;

  localparam int unsigned SW    = SAMPLE_W;
  localparam int unsigned SUM_W = SW + 4;
  localparam int unsigned TAG_W = CW + RW + 1;
  localparam int unsigned WX    = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int unsigned HX    = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;

  cfg_t cfg;

  logic [WX-1:0]   gw_x, w_x;
  logic [HX-1:0]   gh_x, h_x;
  logic [CW:0]     w_lim, c_inc;
  logic [RW:0]     h_lim, r_inc;
  logic [CW-1:0]   col_q, c_cur, col_d;
  logic [RW-1:0]   row_q, r_cur, row_d, r_nxt;
  logic            col_wrap, emit_d, last_d, accept;

  // Input stage.
  logic            v1_q, emit1_q;
  logic [SW-1:0]   x1_q;
  logic [CW-1:0]   c1_q;
  logic [TAG_W-1:0] tag1_q;
  // Line buffer stage.
  logic            v2_q, emit2_q;
  logic [SW-1:0]   x2_q;
  logic [CW-1:0]   c2_q;
  logic [TAG_W-1:0] tag2_q;

  logic            rdy1, rdy2, buf_wr;
  logic [2*SW-1:0] rd_data;
  logic signed [SW-1:0] rd_above, rd_two_above;
  logic signed [SW-1:0] win_left_q, win_center_q, win_up_q, win_down_q;
  logic signed [SUM_W-1:0] sum_d;

  logic            sc_ready, res_sat;
  logic [LAP_W-1:0] res_lap;
  logic [TAG_W-1:0] res_tag;

  fpls_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Clamp the grid size to the supported range.
  always_comb begin
    gw_x = WX'(cfg.grid_width);
    gh_x = HX'(cfg.grid_height);
    if (gw_x < WX'(MIN_DIM)) begin
      w_x = WX'(MIN_DIM);
    end else if (gw_x > WX'(MAX_WIDTH)) begin
      w_x = WX'(MAX_WIDTH);
    end else begin
      w_x = gw_x;
    end
    if (gh_x < HX'(MIN_DIM)) begin
      h_x = HX'(MIN_DIM);
    end else if (gh_x > HX'(MAX_HEIGHT)) begin
      h_x = HX'(MAX_HEIGHT);
    end else begin
      h_x = gh_x;
    end
  end
  assign w_lim = w_x[CW:0];
  assign h_lim = h_x[RW:0];

  // Position of the arriving sample and the next position.
  always_comb begin
    c_cur    = ({1'b0, col_q} >= w_lim) ? '0 : col_q;
    r_cur    = ({1'b0, row_q} >= h_lim) ? '0 : row_q;
    c_inc    = {1'b0, c_cur} + (CW+1)'(1);
    r_inc    = {1'b0, r_cur} + (RW+1)'(1);
    col_wrap = (c_inc >= w_lim);
    r_nxt    = (r_inc >= h_lim) ? '0 : r_inc[RW-1:0];
    col_d    = col_wrap ? '0 : c_inc[CW-1:0];
    row_d    = col_wrap ? r_nxt : r_cur;
    emit_d   = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
    last_d   = ({1'b0, c_cur} == (w_lim - (CW+1)'(1))) &&
               ({1'b0, r_cur} == (h_lim - (RW+1)'(1)));
  end

  // Handshake chain: a stage loads when empty or when its beat moves on.
  assign rdy2          = !v2_q || !emit2_q || sc_ready;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && rdy1;
  assign buf_wr        = v2_q && rdy2;

  // Control registers: counters and stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (cfg.restart) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (rdy1) v1_q <= accept;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // Input and line buffer stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q    <= s_axis_tdata;
      c1_q    <= c_cur;
      emit1_q <= emit_d;
      tag1_q  <= {last_d, r_cur - RW'(1), c_cur - CW'(1)};
    end
    if (rdy2) begin
      x2_q    <= x1_q;
      c2_q    <= c1_q;
      emit2_q <= emit1_q;
      tag2_q  <= tag1_q;
    end
  end

  fpls_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (v1_q && rdy2),
    .rd_addr_i (c1_q),
    .rd_data_o (rd_data),
    .wr_en_i   (buf_wr),
    .wr_addr_i (c2_q),
    .wr_data_i ({x2_q, rd_data[2*SW-1:SW]})
  );

  assign rd_above     = rd_data[2*SW-1:SW];
  assign rd_two_above = rd_data[SW-1:0];

  // Window shifts with every sample leaving the line buffer stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= '0;
      win_center_q <= '0;
      win_up_q     <= '0;
      win_down_q   <= '0;
    end else if (buf_wr) begin
      win_left_q   <= win_center_q;
      win_center_q <= rd_above;
      win_up_q     <= rd_two_above;
      win_down_q   <= x2_q;
    end
  end

  // Raw stencil sum: four neighbours minus four times the centre.
  assign sum_d = SUM_W'(win_up_q) + SUM_W'(win_down_q) + SUM_W'(win_left_q) +
                 SUM_W'(rd_above) - (SUM_W'(win_center_q) <<< 2);

  fpls_scale #(
    .TAG_W (TAG_W)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q && emit2_q),
    .in_ready_o  (sc_ready),
    .in_sum_i    (sum_d),
    .in_tag_i    (tag2_q),
    .gain_i      (cfg.inv_h_sq),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_lap_o   (res_lap),
    .out_sat_o   (res_sat),
    .out_tag_o   (res_tag)
  );

  // Pack the result beat.
  always_comb begin
    m_axis_tdata                         = '0;
    m_axis_tdata[LAP_W-1:0]              = res_lap;
    m_axis_tdata[LAP_W+CW-1:LAP_W]       = res_tag[CW-1:0];
    m_axis_tdata[LAP_W+CW+RW-1:LAP_W+CW] = res_tag[CW+RW-1:CW];
  end
  assign m_axis_tuser = res_sat;
  assign m_axis_tlast = res_tag[TAG_W-1];

  // Counters never leave the grid in use.
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < w_lim)
    else $error("column counter beyond grid width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_q} < h_lim)
    else $error("row counter beyond grid height");

  // A sample blocked in the input stage is neither lost nor overwritten.
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> (v1_q && $stable(x1_q)))
    else $error("blocked input sample changed");

endmodule
